>>> rtl/rfa_pkg.sv
// rational fraction alu: shared types, constants and the microcode program
package rfa_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;
  localparam int PC_BITS       = 5;

  // operation codes of the func field
  localparam logic [1:0] F_ADD = 2'd0;
  localparam logic [1:0] F_SUB = 2'd1;
  localparam logic [1:0] F_MUL = 2'd2;
  localparam logic [1:0] F_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [FIELD_BITS-1:0] a_num;
    logic signed [FIELD_BITS-1:0] a_den;
    logic signed [FIELD_BITS-1:0] b_num;
    logic signed [FIELD_BITS-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_num;
    logic signed [FIELD_BITS-1:0] res_den;
    logic                         div_error;
  } out_word_t;

  typedef enum logic [3:0] {
    U_MUL,
    U_DIV,
    U_REM,
    U_ADDSUB,
    U_MOV,
    U_JZ,
    U_JMP,
    U_OUT,
    U_OUT_ERR
  } uop_t;

  typedef enum logic [3:0] {
    R_AN,
    R_AD,
    R_BN,
    R_BD,
    R_X,
    R_Y,
    R_L,
    R_SA,
    R_SB,
    R_NA
  } reg_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } seq_state_t;

  typedef struct packed {
    uop_t               op;
    reg_sel_t           src_a;
    reg_sel_t           src_b;
    reg_sel_t           dest;
    logic               swap;
    logic [PC_BITS-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } alu_req_t;

  // program entry points and jump targets
  localparam logic [PC_BITS-1:0] PC_MUL    = 5'd0;
  localparam logic [PC_BITS-1:0] PC_DIV    = 5'd3;
  localparam logic [PC_BITS-1:0] PC_ADDSUB = 5'd6;
  localparam logic [PC_BITS-1:0] PC_LOOP   = 5'd10;
  localparam logic [PC_BITS-1:0] PC_SCALE  = 5'd13;
  localparam logic [PC_BITS-1:0] PC_ERR    = 5'd24;

  function automatic uword_t mk(input uop_t op, input reg_sel_t a, input reg_sel_t b,
                                input reg_sel_t d, input logic swap,
                                input logic [PC_BITS-1:0] tgt);
    uword_t w;
    w.op     = op;
    w.src_a  = a;
    w.src_b  = b;
    w.dest   = d;
    w.swap   = swap;
    w.target = tgt;
    return w;
  endfunction

  function automatic logic [PC_BITS-1:0] rfa_entry(input logic [1:0] func);
    logic [PC_BITS-1:0] e;
    case (func)
      F_MUL:   e = PC_MUL;
      F_DIV:   e = PC_DIV;
      default: e = PC_ADDSUB;
    endcase
    return e;
  endfunction

  function automatic uword_t rfa_ucode(input logic [PC_BITS-1:0] pc);
    uword_t w;
    case (pc)
      // multiply
      5'd0:  w = mk(U_MUL,    R_AN, R_BN, R_X,  1'b0, PC_MUL);
      5'd1:  w = mk(U_MUL,    R_AD, R_BD, R_Y,  1'b0, PC_MUL);
      5'd2:  w = mk(U_OUT,    R_AN, R_AN, R_AN, 1'b0, PC_MUL);
      // divide
      5'd3:  w = mk(U_MUL,    R_AN, R_BD, R_X,  1'b0, PC_MUL);
      5'd4:  w = mk(U_MUL,    R_AD, R_BN, R_Y,  1'b0, PC_MUL);
      5'd5:  w = mk(U_OUT,    R_AN, R_AN, R_AN, 1'b0, PC_MUL);
      // add / subtract
      5'd6:  w = mk(U_JZ,     R_AD, R_AN, R_AN, 1'b0, PC_ERR);
      5'd7:  w = mk(U_JZ,     R_BD, R_AN, R_AN, 1'b0, PC_ERR);
      5'd8:  w = mk(U_MOV,    R_AD, R_AN, R_X,  1'b0, PC_MUL);
      5'd9:  w = mk(U_MOV,    R_BD, R_AN, R_Y,  1'b0, PC_MUL);
      // euclid loop: x <= y, y <= x rem y
      5'd10: w = mk(U_JZ,     R_Y,  R_AN, R_AN, 1'b0, PC_SCALE);
      5'd11: w = mk(U_REM,    R_X,  R_Y,  R_Y,  1'b1, PC_MUL);
      5'd12: w = mk(U_JMP,    R_AN, R_AN, R_AN, 1'b0, PC_LOOP);
      5'd13: w = mk(U_MUL,    R_AD, R_BD, R_L,  1'b0, PC_MUL);
      5'd14: w = mk(U_DIV,    R_L,  R_X,  R_L,  1'b0, PC_MUL);
      5'd15: w = mk(U_DIV,    R_L,  R_AD, R_SA, 1'b0, PC_MUL);
      5'd16: w = mk(U_DIV,    R_L,  R_BD, R_SB, 1'b0, PC_MUL);
      5'd17: w = mk(U_JZ,     R_SA, R_AN, R_AN, 1'b0, PC_ERR);
      5'd18: w = mk(U_JZ,     R_SB, R_AN, R_AN, 1'b0, PC_ERR);
      5'd19: w = mk(U_MUL,    R_AN, R_SA, R_NA, 1'b0, PC_MUL);
      5'd20: w = mk(U_MUL,    R_BN, R_SB, R_X,  1'b0, PC_MUL);
      5'd21: w = mk(U_ADDSUB, R_NA, R_X,  R_X,  1'b0, PC_MUL);
      5'd22: w = mk(U_MUL,    R_AD, R_SA, R_Y,  1'b0, PC_MUL);
      5'd23: w = mk(U_OUT,    R_AN, R_AN, R_AN, 1'b0, PC_MUL);
      default: w = mk(U_OUT_ERR, R_AN, R_AN, R_AN, 1'b0, PC_MUL);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/rfa_alu.sv
// rational fraction alu: iterative multiply and truncating divide / remainder unit
module rfa_alu
  import rfa_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  alu_req_t             req,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  localparam int CHUNK     = (WORD_BITS < 16) ? WORD_BITS : 16;
  localparam int MUL_STEPS = (WORD_BITS + CHUNK - 1) / CHUNK;
  localparam int CW        = $clog2(WORD_BITS + 1);

  logic                 busy;
  uop_t                 op;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] mc;
  logic [WORD_BITS-1:0] mp;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] dvs;
  logic                 neg_q;
  logic                 neg_r;

  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;
  logic [WORD_BITS-1:0] part;
  logic [WORD_BITS:0]   r2;
  logic                 ge;
  logic [WORD_BITS:0]   r2_sub;
  logic                 last;

  assign mag_a  = a[WORD_BITS-1] ? -a : a;
  assign mag_b  = b[WORD_BITS-1] ? -b : b;
  assign part   = mc * WORD_BITS'(mp[CHUNK-1:0]);
  assign r2     = {rem, quo[WORD_BITS-1]};
  assign ge     = (r2 >= {1'b0, dvs});
  assign r2_sub = r2 - {1'b0, dvs};
  assign last   = (op == U_MUL) ? (cnt == CW'(MUL_STEPS - 1)) : (cnt == CW'(WORD_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op    <= req.op;
      cnt   <= '0;
      mc    <= a;
      mp    <= b;
      acc   <= '0;
      rem   <= '0;
      quo   <= mag_a;
      dvs   <= mag_b;
      neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      neg_r <= a[WORD_BITS-1];
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (op == U_MUL) begin
        acc <= acc + part;
        mc  <= mc << CHUNK;
        mp  <= mp >> CHUNK;
      end else begin
        // restoring step, one quotient bit
        rem <= ge ? r2_sub[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], ge};
      end
    end
  end

  always_comb begin
    case (op)
      U_DIV:   result = neg_q ? -quo : quo;
      U_REM:   result = neg_r ? -rem : rem;
      default: result = acc;
    endcase
  end

endmodule

>>> rtl/rational_fraction_alu_top.sv
// rational fraction alu: microcoded sequencer, operand registers and result register
// multiply and divide take two products each; add/subtract runs a euclid remainder loop,
// then three divides and four products with control steps between; a zero denominator or
// scale factor ends the add/subtract early with an error result
// one word at a time, the next taken in the cycle after the result loads; a held result stalls it
// synchronous reset clears the sequencer and the result valid flag, not the data registers
module rational_fraction_alu_top
  import rfa_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp
);

  seq_state_t           state;
  seq_state_t           state_next;
  logic [PC_BITS-1:0]   pc;
  logic [PC_BITS-1:0]   pc_next;
  logic                 sub;
  logic [WORD_BITS-1:0] an, ad, bn, bd, x, y, l, sa, sb, na;

  uword_t               uw;
  logic [WORD_BITS-1:0] opa;
  logic [WORD_BITS-1:0] opb;
  logic                 req_acc;
  logic                 slot_free;
  logic                 is_unit;
  logic                 is_out;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_val;
  logic                 out_load;
  alu_req_t             alu_req;
  logic                 alu_done;
  logic [WORD_BITS-1:0] alu_res;

  assign uw        = rfa_ucode(pc);
  assign req_acc   = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign is_unit   = (uw.op == U_MUL) || (uw.op == U_DIV) || (uw.op == U_REM);
  assign is_out    = (uw.op == U_OUT) || (uw.op == U_OUT_ERR);

  always_comb begin
    case (uw.src_a)
      R_AN:    opa = an;
      R_AD:    opa = ad;
      R_BN:    opa = bn;
      R_BD:    opa = bd;
      R_X:     opa = x;
      R_Y:     opa = y;
      R_L:     opa = l;
      R_SA:    opa = sa;
      R_SB:    opa = sb;
      R_NA:    opa = na;
      default: opa = an;
    endcase
  end

  always_comb begin
    case (uw.src_b)
      R_AN:    opb = an;
      R_AD:    opb = ad;
      R_BN:    opb = bn;
      R_BD:    opb = bd;
      R_X:     opb = x;
      R_Y:     opb = y;
      R_L:     opb = l;
      R_SA:    opb = sa;
      R_SB:    opb = sb;
      R_NA:    opb = na;
      default: opb = an;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_acc) state_next = S_RUN;
      end
      S_RUN: begin
        if (is_unit) state_next = S_WAIT;
        else if (is_out && slot_free) state_next = S_IDLE;
      end
      S_WAIT: begin
        if (alu_done) state_next = S_RUN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready     = (state == S_IDLE);
    alu_req.start = 1'b0;
    alu_req.op    = uw.op;
    wr_en         = 1'b0;
    wr_val        = alu_res;
    out_load      = 1'b0;
    pc_next       = pc;
    case (state)
      S_IDLE: begin
        if (req_acc) pc_next = rfa_entry(req.func);
      end
      S_RUN: begin
        case (uw.op)
          U_MUL, U_DIV, U_REM: alu_req.start = 1'b1;
          U_ADDSUB: begin
            wr_en   = 1'b1;
            wr_val  = sub ? (opa - opb) : (opa + opb);
            pc_next = pc + 1'b1;
          end
          U_MOV: begin
            wr_en   = 1'b1;
            wr_val  = opa;
            pc_next = pc + 1'b1;
          end
          U_JZ:      pc_next = (opa == '0) ? uw.target : pc + 1'b1;
          U_JMP:     pc_next = uw.target;
          U_OUT, U_OUT_ERR: out_load = slot_free;
          default:   pc_next = pc;
        endcase
      end
      S_WAIT: begin
        if (alu_done) begin
          wr_en   = 1'b1;
          pc_next = pc + 1'b1;
        end
      end
      default: pc_next = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      an  <= WORD_BITS'(req.a_num);
      ad  <= WORD_BITS'(req.a_den);
      bn  <= WORD_BITS'(req.b_num);
      bd  <= WORD_BITS'(req.b_den);
      sub <= (req.func == F_SUB);
    end
    if (wr_en) begin
      case (uw.dest)
        R_X:     x  <= wr_val;
        R_Y:     y  <= wr_val;
        R_L:     l  <= wr_val;
        R_SA:    sa <= wr_val;
        R_SB:    sb <= wr_val;
        R_NA:    na <= wr_val;
        default: na <= na;
      endcase
      // euclid step moves the old divisor down
      if (uw.swap) x <= y;
    end
    if (out_load) begin
      if (uw.op == U_OUT_ERR) begin
        rsp.res_num   <= '0;
        rsp.res_den   <= '0;
        rsp.div_error <= 1'b1;
      end else begin
        rsp.res_num   <= FIELD_BITS'(signed'(x));
        rsp.res_den   <= FIELD_BITS'(signed'(y));
        rsp.div_error <= 1'b0;
      end
    end
  end

  rfa_alu #(
    .WORD_BITS(WORD_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .a     (opa),
    .b     (opb),
    .done  (alu_done),
    .result(alu_res)
  );

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_WAIT)
    else $error("unit finished outside a wait step");

  a_start_in_run: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> state == S_RUN && is_unit)
    else $error("unit started by a non-arithmetic step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(rsp_valid && !rsp_ready))
    else $error("result register overwritten while held");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_error |-> rsp.res_num == '0 && rsp.res_den == '0)
    else $error("error result with nonzero fraction");
`endif

endmodule
